@@ src/nec_ir_frame_decoder_core_defines.svh @@
// Assertion helpers for the NEC IR frame decoder.
`ifndef NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NEC_IR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NEC_IR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nec_ir_pkg.sv @@
package nec_ir_pkg;

    localparam int PULSE_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_COUNT  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAME_W    = 32;
    localparam int COUNT_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int CMD_W      = 8;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(FRAME_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD      = 3'd5;

    localparam logic [CFG_W-1:0] RST_MIN_VALID = 16'd250;
    localparam logic [CFG_W-1:0] RST_SHORT     = 16'd1200;
    localparam logic [CFG_W-1:0] RST_LONG      = 16'd2000;
    localparam logic [CFG_W-1:0] RST_REPEAT    = 16'd3000;
    localparam logic [CFG_W-1:0] RST_HEADER    = 16'd6000;
    localparam logic [CFG_W-1:0] RST_LEAD      = 16'd12000;

    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd2;

    localparam int BAND_W = 3;
    localparam logic [BAND_W-1:0] BAND_ZERO   = 3'd0;
    localparam logic [BAND_W-1:0] BAND_ONE    = 3'd1;
    localparam logic [BAND_W-1:0] BAND_REPEAT = 3'd2;
    localparam logic [BAND_W-1:0] BAND_HEADER = 3'd3;
    localparam logic [BAND_W-1:0] BAND_LEAD   = 3'd4;
    localparam logic [BAND_W-1:0] BAND_BAD    = 3'd5;

    typedef struct packed {
        logic               func;
        logic [PULSE_W-1:0] pulse_width;
    } t_in_req;

    typedef struct packed {
        logic [STATUS_W-1:0] read_status;
        logic [CMD_W-1:0]    command_code;
    } t_out_rsp;

    typedef struct packed {
        logic [CFG_W-1:0] min_valid_width;
        logic [CFG_W-1:0] short_limit;
        logic [CFG_W-1:0] long_limit;
        logic [CFG_W-1:0] repeat_limit;
        logic [CFG_W-1:0] header_limit;
        logic [CFG_W-1:0] lead_limit;
    } t_thresholds;

endpackage

@@ src/nec_ir_band.sv @@
module nec_ir_band
    import nec_ir_pkg::*;
(
    input  logic [PULSE_W-1:0] i_pulse_width,
    input  t_thresholds        i_thr,
    output logic [BAND_W-1:0]  o_band
);

    always_comb begin
        if (i_pulse_width < i_thr.min_valid_width) begin
            o_band = BAND_BAD;
        end else if (i_pulse_width < i_thr.short_limit) begin
            o_band = BAND_ZERO;
        end else if (i_pulse_width < i_thr.long_limit) begin
            o_band = BAND_ONE;
        end else if (i_pulse_width < i_thr.repeat_limit) begin
            o_band = BAND_REPEAT;
        end else if (i_pulse_width < i_thr.header_limit) begin
            o_band = BAND_HEADER;
        end else if (i_pulse_width < i_thr.lead_limit) begin
            o_band = BAND_LEAD;
        end else begin
            o_band = BAND_BAD;
        end
    end

endmodule

@@ src/nec_ir_frame_decoder_core.sv @@
// NEC infrared frame decoder. Each request is either a captured pulse period
// (func 0) or a read (func 1). A capture is sorted into a band by the six
// threshold registers and updates the held frame in the cycle it is accepted,
// unless 32 bits are already held; it produces no response. A read produces one
// response in the output register in the cycle after acceptance: status 0 when fewer than 32 bits are
// held, status 1 with the command byte for a frame whose address and command
// match their inverses, status 2 otherwise. One request is accepted per clock;
// the input stalls only while a response sits in the output register and is
// not being taken. Write the threshold registers only while idle.
`include "nec_ir_frame_decoder_core_defines.svh"

module nec_ir_frame_decoder_core
    import nec_ir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_rsp             o_out_rsp,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_thresholds         r_thr;
    logic [FRAME_W-1:0]  r_frame;
    logic [FRAME_W-1:0]  n_frame;
    logic [COUNT_W-1:0]  r_bit_count;
    logic [COUNT_W-1:0]  n_bit_count;
    logic                r_out_valid;
    logic                n_out_valid;
    t_out_rsp            r_out_rsp;
    t_out_rsp            n_out_rsp;

    logic [BAND_W-1:0]   band;
    logic                in_acc;
    logic                frame_full;
    logic                frame_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.min_valid_width <= RST_MIN_VALID;
            r_thr.short_limit     <= RST_SHORT;
            r_thr.long_limit      <= RST_LONG;
            r_thr.repeat_limit    <= RST_REPEAT;
            r_thr.header_limit    <= RST_HEADER;
            r_thr.lead_limit      <= RST_LEAD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_VALID: r_thr.min_valid_width <= i_cfg_data;
                CFG_SHORT:     r_thr.short_limit     <= i_cfg_data;
                CFG_LONG:      r_thr.long_limit      <= i_cfg_data;
                CFG_REPEAT:    r_thr.repeat_limit    <= i_cfg_data;
                CFG_HEADER:    r_thr.header_limit    <= i_cfg_data;
                CFG_LEAD:      r_thr.lead_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    nec_ir_band u_band (
        .i_pulse_width (i_in_req.pulse_width),
        .i_thr         (r_thr),
        .o_band        (band)
    );

    assign frame_full = (r_bit_count == FULL_COUNT);
    assign frame_ok   = (r_frame[7:0] == ~r_frame[15:8])
                     && (r_frame[23:16] == ~r_frame[31:24]);

    always_comb begin
        n_frame     = r_frame;
        n_bit_count = r_bit_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rsp   = r_out_rsp;
        if (in_acc) begin
            if (i_in_req.func == FUNC_CAPTURE) begin
                if (!frame_full) begin
                    unique case (band)
                        BAND_ZERO: begin
                            n_frame     = {1'b0, r_frame[FRAME_W-1:1]};
                            n_bit_count = r_bit_count + COUNT_W'(1);
                        end
                        BAND_ONE: begin
                            n_frame     = {1'b1, r_frame[FRAME_W-1:1]};
                            n_bit_count = r_bit_count + COUNT_W'(1);
                        end
                        BAND_HEADER: begin
                            n_frame     = '0;
                            n_bit_count = '0;
                        end
                        BAND_REPEAT: begin
                            if (r_bit_count == '0) begin
                                n_bit_count = FULL_COUNT;
                            end
                        end
                        default: begin
                            n_bit_count = '0;
                        end
                    endcase
                end
            end else begin
                n_out_valid = 1'b1;
                if (!frame_full) begin
                    n_out_rsp.read_status  = STATUS_EMPTY;
                    n_out_rsp.command_code = '0;
                end else if (!frame_ok) begin
                    n_out_rsp.read_status  = STATUS_FAIL;
                    n_out_rsp.command_code = '0;
                    n_frame                = '0;
                    n_bit_count            = '0;
                end else begin
                    n_out_rsp.read_status  = STATUS_OK;
                    n_out_rsp.command_code = r_frame[23:16];
                    n_bit_count            = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_bit_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_frame     <= n_frame;
            r_bit_count <= n_bit_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rsp <= n_out_rsp;
    end

    `NEC_IR_ASSERT_NOW(a_count_range, 1'b1, r_bit_count <= FULL_COUNT, "bit count above 32")
    `NEC_IR_ASSERT_NEXT(a_read_clears, in_acc && i_in_req.func == FUNC_READ && frame_full,
        r_bit_count == '0, "full-frame read did not clear bit count")
    `NEC_IR_ASSERT_NEXT(a_full_holds, in_acc && i_in_req.func == FUNC_CAPTURE && frame_full,
        $stable(r_frame) && r_bit_count == FULL_COUNT, "capture changed a full frame")
    `NEC_IR_ASSERT_NOW(a_cmd_zero, r_out_valid && r_out_rsp.read_status != STATUS_OK,
        r_out_rsp.command_code == '0, "command nonzero without valid status")

endmodule

@@ tb/nec_ir_decode_check.sv @@
module nec_ir_decode_check
    import nec_ir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_req              i_in_req,

    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_rsp             i_out_rsp,

    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    output int                   o_mismatches,
    output int                   o_reads_open
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]   limit_reg [CFG_COUNT];
    logic [FRAME_W-1:0] frame_bits = '0;
    logic [COUNT_W-1:0] bits_held = '0;
    t_out_rsp           read_answers_q [$];
    int                 mismatches = 0;
    int                 open_reads = 0;

    assign o_mismatches = mismatches;
    assign o_reads_open = open_reads;

    function automatic logic [BAND_W-1:0] band_of(logic [PULSE_W-1:0] w);
        if (w < limit_reg[CFG_MIN_VALID]) return BAND_BAD;
        if (w < limit_reg[CFG_SHORT])     return BAND_ZERO;
        if (w < limit_reg[CFG_LONG])      return BAND_ONE;
        if (w < limit_reg[CFG_REPEAT])    return BAND_REPEAT;
        if (w < limit_reg[CFG_HEADER])    return BAND_HEADER;
        if (w < limit_reg[CFG_LEAD])      return BAND_LEAD;
        return BAND_BAD;
    endfunction

    task automatic apply_capture(logic [PULSE_W-1:0] w);
        if (bits_held == FULL_COUNT) return;
        case (band_of(w))
            BAND_ZERO: begin
                frame_bits = {1'b0, frame_bits[FRAME_W-1:1]};
                bits_held  = bits_held + 1'b1;
            end
            BAND_ONE: begin
                frame_bits = {1'b1, frame_bits[FRAME_W-1:1]};
                bits_held  = bits_held + 1'b1;
            end
            BAND_HEADER: begin
                frame_bits = '0;
                bits_held  = '0;
            end
            BAND_REPEAT: begin
                if (bits_held == '0) bits_held = FULL_COUNT;
            end
            default: begin
                bits_held = '0;
            end
        endcase
    endtask

    task automatic answer_read(output t_out_rsp rsp);
        rsp = '0;
        if (bits_held != FULL_COUNT) begin
            rsp.read_status = STATUS_EMPTY;
        end else if (frame_bits[7:0] != ~frame_bits[15:8] ||
                     frame_bits[23:16] != ~frame_bits[31:24]) begin
            rsp.read_status = STATUS_FAIL;
            frame_bits = '0;
            bits_held  = '0;
        end else begin
            rsp.read_status  = STATUS_OK;
            rsp.command_code = frame_bits[23:16];
            bits_held = '0;
        end
    endtask

    task automatic flag(string what, int expd, int got);
        if (mismatches < 10)
            $display("%0t read response %s: expected %0d, got %0d", $time, what, expd, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (!i_rst_n) begin
            limit_reg[CFG_MIN_VALID] = RST_MIN_VALID;
            limit_reg[CFG_SHORT]     = RST_SHORT;
            limit_reg[CFG_LONG]      = RST_LONG;
            limit_reg[CFG_REPEAT]    = RST_REPEAT;
            limit_reg[CFG_HEADER]    = RST_HEADER;
            limit_reg[CFG_LEAD]      = RST_LEAD;
            frame_bits = '0;
            bits_held  = '0;
            read_answers_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (read_answers_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t response with no read pending: status %0d command %0d",
                                 $time, i_out_rsp.read_status, i_out_rsp.command_code);
                    mismatches++;
                end else begin
                    want = read_answers_q.pop_front();
                    if (i_out_rsp.read_status != want.read_status)
                        flag("status", want.read_status, i_out_rsp.read_status);
                    if (i_out_rsp.command_code != want.command_code)
                        flag("command", want.command_code, i_out_rsp.command_code);
                end
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < CFG_COUNT)
                limit_reg[i_cfg_index] = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_in_req.func == FUNC_CAPTURE) begin
                    apply_capture(i_in_req.pulse_width);
                end else begin
                    answer_read(want);
                    read_answers_q.push_back(want);
                end
            end
        end
        open_reads = read_answers_q.size();
    end

endmodule

@@ tb/nec_ir_frame_decoder_core_test.sv @@
module nec_ir_frame_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import nec_ir_pkg::*;

    localparam int CYCLE_LIMIT = 250000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_req              in_req = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_rsp             out_rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   mismatches;
    int                   reads_open;
    int                   cycles = 0;
    int                   sent = 0;
    int                   burst_left = 0;
    logic [15:0]          rx_tick = '0;
    logic [CFG_W-1:0]     lim [CFG_COUNT];

    nec_ir_frame_decoder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nec_ir_decode_check check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_rsp    (out_rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_reads_open (reads_open)
    );

    always #5ns clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stall pattern steps through four out_ready modes, chosen by rx_tick[7:6]
    always @(negedge clk) begin
        rx_tick <= rx_tick + 1'b1;
        case (rx_tick[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (rx_tick[2:0] == 3'd7);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send(logic is_read, logic [PULSE_W-1:0] width);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= '{is_read, width};
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reads_open != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_limits();
        settle();
        write_limit(CFG_MIN_VALID, lim[CFG_MIN_VALID]);
        write_limit(CFG_SHORT, lim[CFG_SHORT]);
        write_limit(CFG_LONG, lim[CFG_LONG]);
        write_limit(CFG_REPEAT, lim[CFG_REPEAT]);
        write_limit(CFG_HEADER, lim[CFG_HEADER]);
        write_limit(CFG_LEAD, lim[CFG_LEAD]);
    endtask

    task automatic set_limits(int a, int b, int c, int d, int e, int f);
        lim[CFG_MIN_VALID] = CFG_W'(a);
        lim[CFG_SHORT]     = CFG_W'(b);
        lim[CFG_LONG]      = CFG_W'(c);
        lim[CFG_REPEAT]    = CFG_W'(d);
        lim[CFG_HEADER]    = CFG_W'(e);
        lim[CFG_LEAD]      = CFG_W'(f);
    endtask

    task automatic ascending_limits();
        int v;
        v = $urandom_range(0, 400);
        lim[CFG_MIN_VALID] = CFG_W'(v);
        v += $urandom_range(1, 12000);
        lim[CFG_SHORT] = CFG_W'(v);
        v += $urandom_range(1, 12000);
        lim[CFG_LONG] = CFG_W'(v);
        v += $urandom_range(1, 12000);
        lim[CFG_REPEAT] = CFG_W'(v);
        v += $urandom_range(1, 12000);
        lim[CFG_HEADER] = CFG_W'(v);
        v += $urandom_range(1, 12000);
        lim[CFG_LEAD] = CFG_W'(v);
    endtask

    function automatic logic [PULSE_W-1:0] width_in(int lo, int hi);
        if (hi > lo) return PULSE_W'($urandom_range(lo, hi - 1));
        return PULSE_W'($urandom);
    endfunction

    function automatic logic [PULSE_W-1:0] bad_width();
        if (lim[CFG_MIN_VALID] != 0 && $urandom_range(0, 1))
            return PULSE_W'($urandom_range(0, lim[CFG_MIN_VALID] - 1));
        return PULSE_W'($urandom_range(lim[CFG_LEAD], 65535));
    endfunction

    function automatic logic [PULSE_W-1:0] bit_width(logic b);
        if (b) return width_in(lim[CFG_SHORT], lim[CFG_LONG]);
        return width_in(lim[CFG_MIN_VALID], lim[CFG_SHORT]);
    endfunction

    function automatic logic [PULSE_W-1:0] repeat_width();
        return width_in(lim[CFG_LONG], lim[CFG_REPEAT]);
    endfunction

    function automatic logic [PULSE_W-1:0] header_width();
        return width_in(lim[CFG_REPEAT], lim[CFG_HEADER]);
    endfunction

    function automatic logic [PULSE_W-1:0] lead_width();
        return width_in(lim[CFG_HEADER], lim[CFG_LEAD]);
    endfunction

    function automatic logic [PULSE_W-1:0] any_width();
        case ($urandom_range(0, 6))
            0:       return PULSE_W'($urandom);
            1:       return bit_width(1'b0);
            2:       return bit_width(1'b1);
            3:       return repeat_width();
            4:       return header_width();
            5:       return lead_width();
            default: return bad_width();
        endcase
    endfunction

    task automatic run_traffic(int n);
        int               stop_at;
        int               pick;
        int               nbits;
        logic [7:0]       addr;
        logic [7:0]       cmd;
        logic [FRAME_W-1:0] word;
        stop_at = sent + n;
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                addr = 8'($urandom);
                cmd  = 8'($urandom);
                if ($urandom_range(0, 3) != 0) word = {~cmd, cmd, ~addr, addr};
                else word = FRAME_W'($urandom);
                send(FUNC_CAPTURE, header_width());
                for (int k = 0; k < FRAME_W; k++) send(FUNC_CAPTURE, bit_width(word[k]));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send(FUNC_CAPTURE, any_width());
                send(FUNC_READ, PULSE_W'($urandom));
                case ($urandom_range(0, 2))
                    0: begin
                        send(FUNC_CAPTURE, repeat_width());
                        send(FUNC_READ, PULSE_W'($urandom));
                    end
                    1: send(FUNC_READ, PULSE_W'($urandom));
                    default: ;
                endcase
            end else if (pick < 75) begin
                nbits = $urandom_range(0, FRAME_W - 1);
                send(FUNC_CAPTURE, header_width());
                repeat (nbits) send(FUNC_CAPTURE, bit_width(1'($urandom)));
                case ($urandom_range(0, 3))
                    0:       send(FUNC_CAPTURE, lead_width());
                    1:       send(FUNC_CAPTURE, bad_width());
                    2:       send(FUNC_CAPTURE, repeat_width());
                    default: send(FUNC_CAPTURE, header_width());
                endcase
                send(FUNC_READ, PULSE_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 2) == 0) send(FUNC_READ, PULSE_W'($urandom));
                    else send(FUNC_CAPTURE, any_width());
                end
            end
        end
    endtask

    initial begin
        set_limits(RST_MIN_VALID, RST_SHORT, RST_LONG, RST_REPEAT, RST_HEADER, RST_LEAD);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // band edges at reset thresholds
        send(FUNC_READ, 16'h0000);
        send(FUNC_CAPTURE, 16'h0000);
        send(FUNC_CAPTURE, 16'hFFFF);
        send(FUNC_CAPTURE, RST_MIN_VALID - 1'b1);
        send(FUNC_CAPTURE, RST_MIN_VALID);
        send(FUNC_CAPTURE, RST_SHORT - 1'b1);
        send(FUNC_CAPTURE, RST_SHORT);
        send(FUNC_CAPTURE, RST_LONG - 1'b1);
        send(FUNC_CAPTURE, RST_LONG);
        send(FUNC_CAPTURE, RST_REPEAT - 1'b1);
        send(FUNC_CAPTURE, RST_REPEAT);
        send(FUNC_CAPTURE, RST_HEADER - 1'b1);
        send(FUNC_CAPTURE, RST_HEADER);
        send(FUNC_CAPTURE, RST_LEAD - 1'b1);
        send(FUNC_CAPTURE, RST_LEAD);
        send(FUNC_READ, 16'hFFFF);
        // repeat on empty count marks a zero frame full, then fails the check
        send(FUNC_CAPTURE, RST_LONG);
        send(FUNC_CAPTURE, RST_MIN_VALID);
        send(FUNC_READ, 16'h5A5A);
        send(FUNC_READ, 16'hA5A5);
        send(FUNC_CAPTURE, RST_REPEAT - 1'b1);
        send(FUNC_READ, 16'h0000);

        run_traffic(220);
        ascending_limits();
        program_limits();
        run_traffic(180);
        set_limits(0, 0, 0, 0, 0, 0);
        program_limits();
        run_traffic(20);
        set_limits(0, 65535, 65535, 65535, 65535, 65535);
        program_limits();
        run_traffic(30);
        set_limits(RST_LEAD, RST_HEADER, RST_REPEAT, RST_LONG, RST_SHORT, RST_MIN_VALID);
        program_limits();
        run_traffic(30);
        set_limits(65535, 65535, 65535, 65535, 65535, 65535);
        program_limits();
        run_traffic(20);
        set_limits(1, 2, 3, 4, 5, 6);
        program_limits();
        run_traffic(60);
        ascending_limits();
        program_limits();
        run_traffic(180);
        set_limits(RST_MIN_VALID, RST_SHORT, RST_LONG, RST_REPEAT, RST_HEADER, RST_LEAD);
        program_limits();
        run_traffic(80);

        settle();
        if (mismatches == 0 && reads_open == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/nec_ir_pkg.sv
src/nec_ir_band.sv
src/nec_ir_frame_decoder_core.sv
tb/nec_ir_decode_check.sv
tb/nec_ir_frame_decoder_core_test.sv
